FILE: design/tufr_pkg.sv
// shared constants and types for the table update frame receiver
package tufr_pkg;

   localparam int unsigned PLUGIN_RECORD_BYTES = 16;
   localparam int unsigned LINK_RECORD_BYTES   = 16;
   localparam int unsigned PLUGIN_COUNT        = 16;
   localparam int unsigned LINK_COUNT          = 16;

   localparam int unsigned PLUGIN_TABLE_BYTES = PLUGIN_COUNT * PLUGIN_RECORD_BYTES;
   localparam int unsigned LINK_TABLE_BYTES   = LINK_COUNT * LINK_RECORD_BYTES;
   localparam int unsigned DUMP_BYTES         = PLUGIN_TABLE_BYTES + LINK_TABLE_BYTES;

   localparam int unsigned STAGE_DEPTH = (PLUGIN_RECORD_BYTES > LINK_RECORD_BYTES) ?
                                         PLUGIN_RECORD_BYTES : LINK_RECORD_BYTES;
   localparam int unsigned STAGE_AW    = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;

   localparam int unsigned POS_MAX = (DUMP_BYTES > STAGE_DEPTH + 2) ?
                                     DUMP_BYTES : STAGE_DEPTH + 2;
   localparam int unsigned POS_W   = $clog2(POS_MAX + 1);

   localparam int unsigned ADDR_W = 13;
   localparam int unsigned DATA_W = 24;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_L = 8'h4C;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_DUMP   = 4'b0010,
      MODE_PLUGIN = 4'b0100,
      MODE_LINK   = 4'b1000
   } mode_type;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_WRITE  = 2'd0;
   localparam kind_type KIND_SAVE   = 2'd1;
   localparam kind_type KIND_REJECT = 2'd2;

   typedef enum logic [1:0] {
      SEQ_WAIT = 2'b01,
      SEQ_EMIT = 2'b10
   } seq_type;

   typedef struct packed {
      logic [7:0]        write_data;
      logic [ADDR_W-1:0] byte_address;
      logic              region;
      kind_type          kind;
   } rsp_type;

endpackage

FILE: design/table_update_frame_receiver_top.sv
// table update frame receiver: byte stream in, table write commands out
//
//  channel | dir | payload                                    | transaction
//  req_    | in  | tdata[7:0] rx_byte                         | one received byte
//  rsp_    | out | tdata kind,region,byte_address,write_data; | one table command
//          |     | tlast marks last result of a byte          |
//
// a matching checksum byte with an index inside the table sends one command per
// record byte through the output register, one per cycle while the output is
// not stalled, and no further byte is taken until the last command is loaded.
// the output register holds a result under back pressure and req_tready stays
// low until it can be reloaded. reset is synchronous and returns to idle.
module table_update_frame_receiver_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] rx_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tufr_pkg::DATA_W-1:0] rsp_tdata,   // [1:0] kind, [2] region,
                                                    // [15:3] byte_address, [23:16] write_data
   output logic                        rsp_tlast
);
   import tufr_pkg::*;

   seq_type             seq_ff, seq_in;
   mode_type            mode_ff, mode_in;
   logic [7:0]          prev_ff, prev_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [7:0]          index_ff, index_in;
   logic [7:0]          xor_ff, xor_in;
   logic [7:0]          stage_ff [STAGE_DEPTH];
   logic [STAGE_AW-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                emit_region_ff, emit_region_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                can_load;
   logic                accept;
   logic                region;
   logic [POS_W-1:0]    rbytes;
   logic [7:0]          count;
   logic                stage_we;
   logic [STAGE_AW-1:0] stage_slot;
   logic [STAGE_AW-1:0] emit_last_idx;
   logic [ADDR_W-1:0]   base;
   logic [POS_W-1:0]    pos_inc;

   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (seq_ff == SEQ_WAIT) && can_load;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign region  = (mode_ff == MODE_LINK);
   assign rbytes  = region ? POS_W'(LINK_RECORD_BYTES) : POS_W'(PLUGIN_RECORD_BYTES);
   assign count   = region ? 8'(LINK_COUNT) : 8'(PLUGIN_COUNT);
   assign pos_inc = pos_ff + POS_W'(1);
   assign stage_slot = STAGE_AW'(pos_ff - POS_W'(1));
   assign emit_last_idx = emit_region_ff ? STAGE_AW'(LINK_RECORD_BYTES - 1) :
                                           STAGE_AW'(PLUGIN_RECORD_BYTES - 1);

   // record base address; only used when the index is inside the table
   always_comb begin
      if (region) begin
         base = ADDR_W'({5'd0, index_ff} * ADDR_W'(LINK_RECORD_BYTES));
      end else begin
         base = ADDR_W'({5'd0, index_ff} * ADDR_W'(PLUGIN_RECORD_BYTES));
      end
   end

   always_comb begin
      seq_in         = seq_ff;
      mode_in        = mode_ff;
      prev_in        = prev_ff;
      pos_in         = pos_ff;
      index_in       = index_ff;
      xor_in         = xor_ff;
      idx_in         = idx_ff;
      addr_in        = addr_ff;
      emit_region_in = emit_region_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      stage_we       = 1'b0;

      case (seq_ff)
         SEQ_WAIT: begin
            if (accept) begin
               prev_in = req_tdata;
               case (mode_ff)
                  MODE_IDLE: begin
                     if (req_tdata == prev_ff) begin
                        if (req_tdata == CHAR_A) begin
                           mode_in = MODE_DUMP;
                           pos_in  = '0;
                        end else if (req_tdata == CHAR_P) begin
                           mode_in = MODE_PLUGIN;
                           pos_in  = '0;
                        end else if (req_tdata == CHAR_L) begin
                           mode_in = MODE_LINK;
                           pos_in  = '0;
                        end
                     end
                  end
                  MODE_DUMP: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (pos_ff < POS_W'(PLUGIN_TABLE_BYTES)) begin
                        rsp_data_in = '{write_data: req_tdata,
                                        byte_address: ADDR_W'(pos_ff),
                                        region: 1'b0, kind: KIND_WRITE};
                        pos_in = pos_inc;
                     end else if (pos_ff < POS_W'(DUMP_BYTES)) begin
                        rsp_data_in = '{write_data: req_tdata,
                                        byte_address:
                                           ADDR_W'(pos_ff - POS_W'(PLUGIN_TABLE_BYTES)),
                                        region: 1'b1, kind: KIND_WRITE};
                        pos_in = pos_inc;
                     end else begin
                        rsp_data_in = '{write_data: 8'd0, byte_address: '0,
                                        region: 1'b0, kind: KIND_SAVE};
                        pos_in  = '0;
                        mode_in = MODE_IDLE;
                     end
                  end
                  default: begin
                     // record frame: index, payload, checksum, closing byte
                     if (pos_ff == '0) begin
                        index_in = req_tdata;
                        xor_in   = req_tdata;
                        pos_in   = POS_W'(1);
                     end else if (pos_ff <= rbytes) begin
                        stage_we = 1'b1;
                        xor_in   = xor_ff ^ req_tdata;
                        pos_in   = pos_inc;
                     end else if (pos_ff == rbytes + POS_W'(1)) begin
                        pos_in = pos_inc;
                        if (xor_ff == req_tdata && index_ff < count) begin
                           seq_in         = SEQ_EMIT;
                           idx_in         = '0;
                           addr_in        = base;
                           emit_region_in = region;
                        end else begin
                           rsp_valid_in = 1'b1;
                           rsp_last_in  = 1'b1;
                           rsp_data_in  = '{write_data: 8'd0, byte_address: '0,
                                            region: region, kind: KIND_REJECT};
                        end
                     end else begin
                        pos_in  = '0;
                        mode_in = MODE_IDLE;
                     end
                  end
               endcase
            end
         end
         SEQ_EMIT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (idx_ff == emit_last_idx);
               rsp_data_in  = '{write_data: stage_ff[idx_ff], byte_address: addr_ff,
                                region: emit_region_ff, kind: KIND_WRITE};
               idx_in  = idx_ff + STAGE_AW'(1);
               addr_in = addr_ff + ADDR_W'(1);
               if (idx_ff == emit_last_idx) begin
                  seq_in = SEQ_WAIT;
               end
            end
         end
         default: begin
            seq_in = SEQ_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_WAIT;
         mode_ff      <= MODE_IDLE;
         prev_ff      <= '0;
         pos_ff       <= '0;
         index_ff     <= '0;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         mode_ff      <= mode_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         index_ff     <= index_in;
         xor_ff       <= xor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      addr_ff        <= addr_in;
      emit_region_ff <= emit_region_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
      if (stage_we) begin
         stage_ff[stage_slot] <= req_tdata;
      end
   end

endmodule

FILE: design/tufr_checker.sv
// port-level checks for the table update frame receiver, bound to the top level
module tufr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [7:0]                  req_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [tufr_pkg::DATA_W-1:0] rsp_tdata,
   input logic                        rsp_tlast
);
   import tufr_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // no new byte is taken while a result is stuck in the output register
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req accepted while rsp stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] == KIND_WRITE || rsp_tdata[1:0] == KIND_SAVE ||
                     rsp_tdata[1:0] == KIND_REJECT)
      else $error("illegal result kind");

   // save requests and rejects are single results
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != KIND_WRITE |-> rsp_tlast && rsp_tdata[15:3] == 13'd0)
      else $error("save or reject not a single last result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind table_update_frame_receiver_top tufr_checker u_tufr_checker (.*);
